FILE: rtl/core/cma_pkg.sv
// Shared types and constants for the centered moving average block.
// Used by every module under rtl/core; depends on nothing else.
package cma_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int FRAC_BITS   = 8;
    localparam int AVG_BITS    = SAMPLE_BITS + FRAC_BITS;
    localparam int WS_BITS     = 6;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          stream_end;
    } in_word_t;

    typedef struct packed {
        logic signed [AVG_BITS-1:0] average;
        logic                       final_output;
    } out_word_t;

    // Operations of the shared add/subtract unit
    typedef enum logic [2:0] {
        ALU_NONE  = 3'd0,
        ALU_CLEAR = 3'd1,
        ALU_ACC   = 3'd2,
        ALU_ABS   = 3'd3,
        ALU_DIV   = 3'd4,
        ALU_NEG   = 3'd5
    } alu_op_t;

endpackage

FILE: rtl/core/centered_moving_average.sv
// Centered moving average over a sample stream: sequencer, counters, output register.
// Depends on cma_pkg, cma_line and cma_arith.
//
//   channel   signals                         carries
//   src       src_valid / src_ready / src_word  one sample and its stream_end flag
//   res       res_valid / res_ready / res_word  one window mean and final_output flag
//   cfg       cfg_we / cfg_wdata                window_size, write only
//
// Each item is accepted in S_IDLE, then passes S_PICK once per center distance examined.
// For every result it causes (count = samples summed), one shared adder first reads and adds
// the count samples from the delay line, then runs one restoring divide step per quotient
// bit (30 at the default widths), negates and emits.
// A last-of-stream sample repeats this for every pending result.
// Reset needs no clearing pass; the delay line is only read where this stream wrote it.
// A stalled result register holds the sequencer in its emit state.
module centered_moving_average #(
    parameter int MAX_HALF_WINDOW = 31
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            src_valid,
    output logic                            src_ready,
    input  cma_pkg::in_word_t               src_word,
    output logic                            res_valid,
    input  logic                            res_ready,
    output cma_pkg::out_word_t              res_word,
    input  logic                            cfg_we,
    input  logic [cma_pkg::WS_BITS-1:0]     cfg_wdata
);
    import cma_pkg::*;

    localparam int LINE_DEPTH = 2 * MAX_HALF_WINDOW + 2;
    localparam int IDX_W      = $clog2(LINE_DEPTH);
    localparam int SEEN_W     = $clog2(LINE_DEPTH + 1);
    localparam int H_W        = $clog2(MAX_HALF_WINDOW + 1);
    localparam int CNT_W      = $clog2(2 * MAX_HALF_WINDOW + 2);
    localparam int NUM_BITS   = SAMPLE_BITS + CNT_W + FRAC_BITS;
    localparam int STEP_W     = $clog2(NUM_BITS + 1);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_PICK = 7'b0000010,
        S_SUM  = 7'b0000100,
        S_ABS  = 7'b0001000,
        S_DIV  = 7'b0010000,
        S_NEG  = 7'b0100000,
        S_EMIT = 7'b1000000
    } state_t;

    state_t               state_reg, state_next;
    logic [WS_BITS-1:0]   window_size_reg;
    logic [SEEN_W-1:0]    seen_reg, seen_next;
    logic [SEEN_W-1:0]    seen_work_reg, seen_work_next;
    logic [IDX_W-1:0]     wr_slot_reg, wr_slot_next;
    logic [IDX_W-1:0]     newest_reg, newest_next;
    logic [IDX_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [H_W-1:0]       h_reg, h_next;
    logic [H_W-1:0]       d_reg, d_next;
    logic                 last_reg, last_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     issue_reg, issue_next;
    logic                 rd_vld_reg, rd_vld_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic                 res_valid_reg, res_valid_next;
    out_word_t            res_word_reg, res_word_next;

    alu_op_t                      alu_op;
    logic                         mem_we;
    logic signed [SAMPLE_BITS-1:0] rd_data;
    logic signed [AVG_BITS-1:0]   avg;
    logic [WS_BITS-1:0]           ws_half;
    logic [H_W-1:0]               h_new;
    logic [SEEN_W-1:0]            seen_inc;
    logic [IDX_W-1:0]             slot_inc;
    logic [SEEN_W-1:0]            span;
    logic [CNT_W-1:0]             count_sel;
    logic                         last_d;

    assign ws_half  = window_size_reg >> 1;
    assign h_new    = (int'(ws_half) > MAX_HALF_WINDOW) ? H_W'(MAX_HALF_WINDOW)
                                                        : H_W'(ws_half);
    assign seen_inc = (seen_reg < SEEN_W'(LINE_DEPTH)) ? seen_reg + SEEN_W'(1) : seen_reg;
    assign slot_inc = (wr_slot_reg == IDX_W'(LINE_DEPTH - 1)) ? '0
                                                              : wr_slot_reg + IDX_W'(1);
    assign span      = SEEN_W'(d_reg) + SEEN_W'(h_reg) + SEEN_W'(1);
    assign count_sel = (span > seen_work_reg) ? CNT_W'(seen_work_reg) : CNT_W'(span);
    // only the last sample of a stream flushes the outputs below distance h
    assign last_d    = !last_reg || (d_reg == '0);

    assign src_ready = (state_reg == S_IDLE);
    assign res_valid = res_valid_reg;
    assign res_word  = res_word_reg;

    cma_line #(
        .DEPTH (LINE_DEPTH)
    ) u_line (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (wr_slot_reg),
        .wr_data (src_word.sample),
        .rd_addr (rd_ptr_reg),
        .rd_data (rd_data)
    );

    cma_arith #(
        .COUNT_BITS (CNT_W)
    ) u_arith (
        .clk     (clk),
        .op      (alu_op),
        .rd_data (rd_data),
        .count   (count_reg),
        .average (avg)
    );

    always_comb
    begin
        state_next     = state_reg;
        seen_next      = seen_reg;
        seen_work_next = seen_work_reg;
        wr_slot_next   = wr_slot_reg;
        newest_next    = newest_reg;
        rd_ptr_next    = rd_ptr_reg;
        h_next         = h_reg;
        d_next         = d_reg;
        last_next      = last_reg;
        count_next     = count_reg;
        issue_next     = issue_reg;
        rd_vld_next    = 1'b0;
        step_next      = step_reg;
        res_word_next  = res_word_reg;
        res_valid_next = res_valid_reg && !res_ready;
        alu_op         = ALU_NONE;
        mem_we         = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (src_valid)
                begin
                    mem_we         = 1'b1;
                    h_next         = (seen_reg == '0) ? h_new : h_reg;
                    d_next         = (seen_reg == '0) ? h_new : h_reg;
                    newest_next    = wr_slot_reg;
                    seen_work_next = seen_inc;
                    last_next      = src_word.stream_end;
                    seen_next      = src_word.stream_end ? '0 : seen_inc;
                    wr_slot_next   = src_word.stream_end ? '0 : slot_inc;
                    state_next     = S_PICK;
                end
            end
            S_PICK:
            begin
                if (SEEN_W'(d_reg) < seen_work_reg)
                begin
                    count_next  = count_sel;
                    issue_next  = count_sel;
                    rd_ptr_next = newest_reg;
                    alu_op      = ALU_CLEAR;
                    state_next  = S_SUM;
                end
                else if (last_d)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    d_next = d_reg - H_W'(1);
                end
            end
            S_SUM:
            begin
                // walk back from the newest sample; read data arrives in the next cycle
                if (issue_reg != '0)
                begin
                    issue_next  = issue_reg - CNT_W'(1);
                    rd_ptr_next = (rd_ptr_reg == '0) ? IDX_W'(LINE_DEPTH - 1)
                                                     : rd_ptr_reg - IDX_W'(1);
                    rd_vld_next = 1'b1;
                end
                if (rd_vld_reg)
                begin
                    alu_op = ALU_ACC;
                end
                if (issue_reg == '0 && !rd_vld_reg)
                begin
                    state_next = S_ABS;
                end
            end
            S_ABS:
            begin
                alu_op     = ALU_ABS;
                step_next  = STEP_W'(NUM_BITS);
                state_next = S_DIV;
            end
            S_DIV:
            begin
                alu_op    = ALU_DIV;
                step_next = step_reg - STEP_W'(1);
                if (step_reg == STEP_W'(1))
                begin
                    state_next = S_NEG;
                end
            end
            S_NEG:
            begin
                alu_op     = ALU_NEG;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    res_valid_next             = 1'b1;
                    res_word_next.average      = avg;
                    res_word_next.final_output = last_reg && (d_reg == '0);
                    if (last_d)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        d_next     = d_reg - H_W'(1);
                        state_next = S_PICK;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            window_size_reg <= WS_BITS'(1);
            seen_reg        <= '0;
            seen_work_reg   <= '0;
            wr_slot_reg     <= '0;
            newest_reg      <= '0;
            rd_ptr_reg      <= '0;
            h_reg           <= '0;
            d_reg           <= '0;
            last_reg        <= 1'b0;
            count_reg       <= '0;
            issue_reg       <= '0;
            rd_vld_reg      <= 1'b0;
            step_reg        <= '0;
            res_valid_reg   <= 1'b0;
            res_word_reg    <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            if (cfg_we)
            begin
                window_size_reg <= cfg_wdata;
            end
            seen_reg        <= seen_next;
            seen_work_reg   <= seen_work_next;
            wr_slot_reg     <= wr_slot_next;
            newest_reg      <= newest_next;
            rd_ptr_reg      <= rd_ptr_next;
            h_reg           <= h_next;
            d_reg           <= d_next;
            last_reg        <= last_next;
            count_reg       <= count_next;
            issue_reg       <= issue_next;
            rd_vld_reg      <= rd_vld_next;
            step_reg        <= step_next;
            res_valid_reg   <= res_valid_next;
            res_word_reg    <= res_word_next;
        end
    end

    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SUM) |-> (count_reg != '0))
        else $error("window count is zero while summing");

    a_dist_in_half: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (d_reg <= h_reg))
        else $error("center distance exceeds half window");

    a_stream_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (src_valid && src_ready && src_word.stream_end)
        |=> (seen_reg == '0 && wr_slot_reg == '0))
        else $error("stream counters not cleared after last word");

    a_read_in_sum: assert property (@(posedge clk) disable iff (!rst_n)
        rd_vld_reg |-> (state_reg == S_SUM))
        else $error("delay line read outside the summing phase");

    a_load_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(state_reg == S_EMIT))
        else $error("result word loaded outside the emit state");

endmodule

FILE: rtl/core/cma_line.sv
// Sample delay line: one write port and one registered read port.
// Depends on cma_pkg for the sample width.
module cma_line #(
    parameter int DEPTH = 64
) (
    input  logic                                    clk,
    input  logic                                    wr_en,
    input  logic [$clog2(DEPTH)-1:0]                wr_addr,
    input  logic signed [cma_pkg::SAMPLE_BITS-1:0]  wr_data,
    input  logic [$clog2(DEPTH)-1:0]                rd_addr,
    output logic signed [cma_pkg::SAMPLE_BITS-1:0]  rd_data
);
    import cma_pkg::*;

    logic signed [SAMPLE_BITS-1:0] mem_reg [DEPTH];
    logic signed [SAMPLE_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/core/cma_arith.sv
// Shared add/subtract unit with accumulator and restoring divider registers.
// Depends on cma_pkg for alu_op_t and the sample and average widths.
module cma_arith #(
    parameter int COUNT_BITS = 6
) (
    input  logic                                    clk,
    input  cma_pkg::alu_op_t                        op,
    input  logic signed [cma_pkg::SAMPLE_BITS-1:0]  rd_data,
    input  logic [COUNT_BITS-1:0]                   count,
    output logic signed [cma_pkg::AVG_BITS-1:0]     average
);
    import cma_pkg::*;

    localparam int SUM_BITS = SAMPLE_BITS + COUNT_BITS;
    localparam int NUM_BITS = SUM_BITS + FRAC_BITS;
    localparam int ALU_BITS = NUM_BITS + 1;
    localparam int REM_BITS = COUNT_BITS + 1;

    logic signed [SUM_BITS-1:0] acc_reg, acc_next;
    logic [NUM_BITS-1:0]        quo_reg, quo_next;
    logic [REM_BITS-1:0]        rem_reg, rem_next;
    logic                       neg_reg, neg_next;

    logic [ALU_BITS-1:0] alu_a, alu_b, alu_sum;
    logic                alu_sub;
    logic [REM_BITS-1:0] rem_shift;
    logic [SUM_BITS-1:0] mag;

    assign rem_shift = {rem_reg[REM_BITS-2:0], quo_reg[NUM_BITS-1]};

    always_comb
    begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        case (op)
            ALU_ACC:
            begin
                alu_a = ALU_BITS'(acc_reg);
                alu_b = ALU_BITS'(rd_data);
            end
            ALU_ABS:
            begin
                alu_b   = ALU_BITS'(acc_reg);
                alu_sub = 1'b1;
            end
            ALU_DIV:
            begin
                alu_a   = ALU_BITS'(rem_shift);
                alu_b   = ALU_BITS'(count);
                alu_sub = 1'b1;
            end
            ALU_NEG:
            begin
                alu_b   = ALU_BITS'(quo_reg);
                alu_sub = 1'b1;
            end
            default:
            begin
                alu_sub = 1'b0;
            end
        endcase
        alu_sum = alu_a + (alu_sub ? ~alu_b : alu_b) + ALU_BITS'(alu_sub);
    end

    always_comb
    begin
        acc_next = acc_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        neg_next = neg_reg;
        mag      = acc_reg;
        case (op)
            ALU_CLEAR:
            begin
                acc_next = '0;
            end
            ALU_ACC:
            begin
                acc_next = alu_sum[SUM_BITS-1:0];
            end
            ALU_ABS:
            begin
                neg_next = acc_reg[SUM_BITS-1];
                mag      = acc_reg[SUM_BITS-1] ? alu_sum[SUM_BITS-1:0] : acc_reg;
                quo_next = {mag, FRAC_BITS'(0)};
                rem_next = '0;
            end
            ALU_DIV:
            begin
                // negative trial difference: keep the shifted remainder
                if (alu_sum[ALU_BITS-1])
                begin
                    rem_next = rem_shift;
                    quo_next = {quo_reg[NUM_BITS-2:0], 1'b0};
                end
                else
                begin
                    rem_next = alu_sum[REM_BITS-1:0];
                    quo_next = {quo_reg[NUM_BITS-2:0], 1'b1};
                end
            end
            ALU_NEG:
            begin
                if (neg_reg)
                begin
                    quo_next = alu_sum[NUM_BITS-1:0];
                end
            end
            default:
            begin
                acc_next = acc_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        neg_reg <= neg_next;
    end

    assign average = quo_reg[AVG_BITS-1:0];

endmodule
